>>> hdl/uartrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uartrb_pkg;

    // ring depths
    localparam int RX_DEPTH = 128;
    localparam int TX_DEPTH = 128;

    localparam int RX_PTR_W  = $clog2(RX_DEPTH);
    localparam int RX_FILL_W = $clog2(RX_DEPTH + 1);
    localparam int TX_PTR_W  = $clog2(TX_DEPTH);
    localparam int TX_FILL_W = $clog2(TX_DEPTH + 1);

    // width of burst_len + tx fill
    localparam int TX_SUM_W = ((TX_FILL_W > 8) ? TX_FILL_W : 8) + 1;

    localparam logic [RX_FILL_W-1:0] RX_FULL     = RX_FILL_W'(RX_DEPTH);
    localparam logic [RX_FILL_W-1:0] RX_ONE_LEFT = RX_FILL_W'(RX_DEPTH - 1);
    localparam logic [RX_PTR_W-1:0]  RX_LAST_PTR = RX_PTR_W'(RX_DEPTH - 1);
    localparam logic [TX_FILL_W-1:0] TX_FULL     = TX_FILL_W'(TX_DEPTH);
    localparam logic [TX_PTR_W-1:0]  TX_LAST_PTR = TX_PTR_W'(TX_DEPTH - 1);
    localparam logic [TX_SUM_W-1:0]  TX_ROOM     = TX_SUM_W'(TX_DEPTH);

    typedef enum logic [2:0] {
        OP_RX_BYTE   = 3'd0,
        OP_HOST_READ = 3'd1,
        OP_TX_BYTE   = 3'd2,
        OP_TX_READY  = 3'd3,
        OP_OVF_CLEAR = 3'd4
    } opcode_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] byte_in;
        logic       line_error;
        logic [7:0] burst_len;
        logic       burst_first;
    } item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_valid;
        logic       tx_accepted;
        logic [7:0] line_byte;
        logic       line_valid;
        logic       tx_request;
        logic [7:0] rx_level;
        logic       rx_empty;
        logic       overflow_seen;
        logic [7:0] tx_level;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/uart_rx_tx_ring_buffers_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// buffered uart receive/transmit ring stores between a serial line and a host.
// each request carries one operation: byte received, host read, transmit byte,
// transmitter ready or read-clear overflow, and gives exactly one result with
// the popped byte (if any) and the status after the operation. both stores are
// single synchronous memories with a registered read; an operation that
// does not pop a byte loads its result into the output register as it is
// accepted, while a host read or transmitter-ready event that pops a byte
// first waits in a pop state for the memory read. one request is in flight
// at a time; a result waits in an output register so the next request is
// taken as soon as that register is free or draining. store contents are
// undefined after reset and need no clearing pass: only entries counted in
// the fill are ever read, so the block takes requests right after reset.

module uart_rx_tx_ring_buffers_unit
    import uartrb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    // ring pointers, fills and flags
    logic [RX_PTR_W-1:0]  rx_head_reg, rx_head_next;
    logic [RX_PTR_W-1:0]  rx_tail_reg, rx_tail_next;
    logic [RX_FILL_W-1:0] rx_fill_reg, rx_fill_next;
    logic [TX_PTR_W-1:0]  tx_head_reg, tx_head_next;
    logic [TX_PTR_W-1:0]  tx_tail_reg, tx_tail_next;
    logic [TX_FILL_W-1:0] tx_fill_reg, tx_fill_next;
    logic                 ovf_reg, ovf_next;
    logic                 irq_reg, irq_next;
    logic                 rej_reg, rej_next;

    state_t  state_reg, state_next;
    result_t pend_reg;

    logic    accept;
    logic    pop;
    result_t res;
    logic    ovf_out;
    logic [TX_SUM_W-1:0] burst_need;

    // memory ports
    logic       rx_we, rx_re;
    logic       tx_we, tx_re;
    logic [7:0] rx_rdata, tx_rdata;

    // output stage
    logic    out_load;
    result_t out_load_data;
    logic    out_free;

    assign accept     = item_valid && !item_stall;
    assign burst_need = TX_SUM_W'(item.burst_len) + TX_SUM_W'(tx_fill_reg);

    // operation decode and state update, all decided at accept
    always_comb
    begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        rx_fill_next = rx_fill_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        tx_fill_next = tx_fill_reg;
        ovf_next     = ovf_reg;
        irq_next     = irq_reg;
        rej_next     = rej_reg;
        rx_we        = 1'b0;
        rx_re        = 1'b0;
        tx_we        = 1'b0;
        tx_re        = 1'b0;
        pop          = 1'b0;
        res          = '0;
        ovf_out      = ovf_reg;

        if (accept)
        begin
            case (item.opcode)
                OP_RX_BYTE:
                begin
                    // error bytes and bytes arriving at a full store are dropped
                    if (!item.line_error && (rx_fill_reg < RX_FULL))
                    begin
                        rx_we        = 1'b1;
                        rx_head_next = (rx_head_reg == RX_LAST_PTR) ? '0 :
                                       rx_head_reg + 1'b1;
                        rx_fill_next = rx_fill_reg + 1'b1;
                        if (rx_fill_reg == RX_ONE_LEFT)
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                OP_HOST_READ:
                begin
                    if (rx_fill_reg != '0)
                    begin
                        rx_re          = 1'b1;
                        pop            = 1'b1;
                        res.read_valid = 1'b1;
                        rx_tail_next   = (rx_tail_reg == RX_LAST_PTR) ? '0 :
                                         rx_tail_reg + 1'b1;
                        rx_fill_next   = rx_fill_reg - 1'b1;
                    end
                end
                OP_TX_BYTE:
                begin
                    // whole burst checked for room on its first item
                    if (item.burst_first)
                    begin
                        if (burst_need > TX_ROOM)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            rej_next = 1'b0;
                            irq_next = 1'b1;
                        end
                    end
                    if (!rej_next)
                    begin
                        res.tx_accepted = 1'b1;
                        // overlong burst: excess bytes dropped, still accepted
                        if (tx_fill_reg < TX_FULL)
                        begin
                            tx_we        = 1'b1;
                            tx_head_next = (tx_head_reg == TX_LAST_PTR) ? '0 :
                                           tx_head_reg + 1'b1;
                            tx_fill_next = tx_fill_reg + 1'b1;
                        end
                    end
                end
                OP_TX_READY:
                begin
                    if (irq_reg)
                    begin
                        if (tx_fill_reg != '0)
                        begin
                            tx_re          = 1'b1;
                            pop            = 1'b1;
                            res.line_valid = 1'b1;
                            tx_tail_next   = (tx_tail_reg == TX_LAST_PTR) ? '0 :
                                             tx_tail_reg + 1'b1;
                            tx_fill_next   = tx_fill_reg - 1'b1;
                        end
                        else
                        begin
                            irq_next = 1'b0;
                        end
                    end
                end
                OP_OVF_CLEAR:
                begin
                    ovf_next = 1'b0;
                end
                default:
                begin
                    // unused codes report status only
                end
            endcase

            // read-clear reports the flag as it stood before clearing
            ovf_out = (item.opcode == OP_OVF_CLEAR) ? ovf_reg : ovf_next;
        end

        res.tx_request    = irq_next;
        res.rx_level      = 8'(rx_fill_next);
        res.rx_empty      = (rx_fill_next == '0);
        res.overflow_seen = ovf_out;
        res.tx_level      = 8'(tx_fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            rx_fill_reg <= '0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            tx_fill_reg <= '0;
            ovf_reg     <= 1'b0;
            irq_reg     <= 1'b0;
            rej_reg     <= 1'b0;
            state_reg   <= ST_IDLE;
        end
        else
        begin
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            rx_fill_reg <= rx_fill_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            tx_fill_reg <= tx_fill_next;
            ovf_reg     <= ovf_next;
            irq_reg     <= irq_next;
            rej_reg     <= rej_next;
            state_reg   <= state_next;
        end
    end

    // status of a popping request, held while the byte comes out of memory
    always_ff @(posedge clk)
    begin
        if (accept && pop)
        begin
            pend_reg <= res;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && pop)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        item_stall    = 1'b1;
        out_load      = 1'b0;
        out_load_data = res;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall    = !out_free;
                out_load      = accept && !pop;
                out_load_data = res;
            end
            ST_POP:
            begin
                // output slot is empty here: nothing was loaded at accept
                item_stall              = 1'b1;
                out_load                = 1'b1;
                out_load_data           = pend_reg;
                out_load_data.read_byte = pend_reg.read_valid ? rx_rdata : '0;
                out_load_data.line_byte = pend_reg.line_valid ? tx_rdata : '0;
            end
            default:
            begin
                item_stall = 1'b1;
                out_load   = 1'b0;
            end
        endcase
    end

    uartrb_ram #(
        .DEPTH (RX_DEPTH),
        .WIDTH (8)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_we),
        .wr_addr (rx_head_reg),
        .wr_data (item.byte_in),
        .rd_en   (rx_re),
        .rd_addr (rx_tail_reg),
        .rd_data (rx_rdata)
    );

    uartrb_ram #(
        .DEPTH (TX_DEPTH),
        .WIDTH (8)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_we),
        .wr_addr (tx_head_reg),
        .wr_data (item.byte_in),
        .rd_en   (tx_re),
        .rd_addr (tx_tail_reg),
        .rd_data (tx_rdata)
    );

    uartrb_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (out_load_data),
        .stall     (result_stall),
        .valid     (result_valid),
        .data      (result),
        .free      (out_free)
    );

endmodule

`default_nettype wire

>>> hdl/uartrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module uartrb_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/uartrb_out.sv
`timescale 1ns / 1ps
`default_nettype none

module uartrb_out
    import uartrb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_data,
    input  wire logic    stall,
    output logic         valid,
    output result_t      data,
    output logic         free
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // slot can take a new result when empty or being drained this cycle
    assign free = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

>>> hdl/uartrb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module uartrb_checker
    import uartrb_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_stall,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // no new request taken while a result is stuck in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> item_stall)
        else $error("request accepted with result blocked");

    // one operation per result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.read_valid |-> !result.line_valid && !result.tx_accepted)
        else $error("host read result mixed with transmit activity");

    // a byte goes to the line only while the request is raised
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.line_valid |-> result.tx_request)
        else $error("line byte without transmit request");

    // nonzero receive level means the store is not empty
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.rx_level != 8'd0) |-> !result.rx_empty)
        else $error("receive level and empty flag disagree");

endmodule

bind uart_rx_tx_ring_buffers_unit uartrb_checker u_uartrb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
